// File: design/crcurve_pkg.sv
package crcurve_pkg;

  localparam int ADDR_MAX_W = 12;
  localparam int T_MAX_W = 24;
  localparam int OUT_W = 38;
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 16;

  typedef struct packed {
    logic                  is_load;
    logic                  err;
    logic [ADDR_MAX_W-1:0] waddr;
    logic [31:0]           x;
    logic [31:0]           y;
    logic [31:0]           z;
    logic [ADDR_MAX_W-1:0] ra0;
    logic [ADDR_MAX_W-1:0] ra1;
    logic [ADDR_MAX_W-1:0] ra2;
    logic [ADDR_MAX_W-1:0] ra3;
    logic [T_MAX_W-1:0]    tt;
  } cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] pos_x;
    logic [OUT_W-1:0] pos_y;
    logic [OUT_W-1:0] pos_z;
    logic [OUT_W-1:0] tangent_x;
    logic [OUT_W-1:0] tangent_y;
    logic [OUT_W-1:0] tangent_z;
    logic             range_error;
  } result_t;

endpackage

// File: design/crcurve_fifo.sv
module crcurve_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic [$clog2(DEPTH):0] level
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign level = count;
  assign rdata = mem[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule

// File: design/crcurve_front.sv
module crcurve_front #(
  parameter int STORE_DEPTH = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                op,
  input  logic [7:0]          point_addr,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic [7:0]          curve_base,
  input  logic [8:0]          curve_points,
  input  logic [15:0]         global_param,
  output crcurve_pkg::cmd_t   cmd
);

  localparam int GW = (FRAC_BITS > 16) ? FRAC_BITS : 16;
  localparam int SW = FRAC_BITS + 9;
  localparam int AMW = crcurve_pkg::ADDR_MAX_W;

  logic [GW-1:0] gext;
  logic [FRAC_BITS-1:0] frac;
  logic [SW-1:0] s;
  logic [8:0] seg;
  logic [8:0] i0, i1, i2, i3;
  logic [9:0] seg_inc, i2_inc;
  logic [9:0] curve_end;
  logic [9:0] a0, a1, a2, a3;
  logic eval_err;
  logic load_err;

  always_comb begin
    gext = GW'(global_param);
    frac = gext[FRAC_BITS-1:0];
    s = SW'(frac) * SW'(curve_points);
    seg = s[SW-1:FRAC_BITS];
    i0 = (seg == '0) ? (curve_points - 9'd1) : (seg - 9'd1);
    i1 = seg;
    seg_inc = 10'(seg) + 10'd1;
    i2 = (seg_inc == 10'(curve_points)) ? 9'd0 : seg_inc[8:0];
    i2_inc = 10'(i2) + 10'd1;
    i3 = (i2_inc == 10'(curve_points)) ? 9'd0 : i2_inc[8:0];
    a0 = 10'(curve_base) + 10'(i0);
    a1 = 10'(curve_base) + 10'(i1);
    a2 = 10'(curve_base) + 10'(i2);
    a3 = 10'(curve_base) + 10'(i3);
    curve_end = 10'(curve_base) + 10'(curve_points);
    eval_err = (curve_points == '0) || (14'(curve_end) > 14'(STORE_DEPTH));
    load_err = !(14'(point_addr) < 14'(STORE_DEPTH));

    cmd.is_load = !op;
    cmd.err = op ? eval_err : load_err;
    cmd.waddr = AMW'(point_addr);
    cmd.x = coord_x;
    cmd.y = coord_y;
    cmd.z = coord_z;
    cmd.ra0 = AMW'(a0);
    cmd.ra1 = AMW'(a1);
    cmd.ra2 = AMW'(a2);
    cmd.ra3 = AMW'(a3);
    cmd.tt = crcurve_pkg::T_MAX_W'(s[FRAC_BITS-1:0]);
  end

endmodule

// File: design/crcurve_back.sv
module crcurve_back #(
  parameter int STORE_DEPTH = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  crcurve_pkg::cmd_t       cmd,
  input  logic                    cmd_empty,
  output logic                    cmd_pop,
  input  logic [$clog2(crcurve_pkg::RES_DEPTH):0] res_level,
  output logic                    res_push,
  output crcurve_pkg::result_t    res
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = 40;
  localparam int MW = CW + FRAC_BITS + 2;
  localparam int LW = $clog2(crcurve_pkg::RES_DEPTH) + 1;
  localparam int OW = crcurve_pkg::OUT_W;
  localparam logic signed [MW-1:0] HALF = MW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [CW-1:0] ONE = CW'(1);

  logic [95:0] mem0 [STORE_DEPTH];
  logic [95:0] mem1 [STORE_DEPTH];
  logic [95:0] mem2 [STORE_DEPTH];
  logic [95:0] mem3 [STORE_DEPTH];

  logic [LW-1:0] inflight;
  logic credit_ok;
  logic issue;

  logic [95:0] rd0, rd1, rd2, rd3;
  logic v0, v1, v2, v3, v4, v5, v6, v7;
  logic e0, e1, e2, e3, e4, e5, e6, e7;
  logic [FRAC_BITS-1:0] t0, t1, t2, t3, t4, t5;

  logic signed [CW-1:0] c3 [3];
  logic signed [CW-1:0] c3x3 [3];
  logic signed [CW-1:0] c2 [3];
  logic signed [CW-1:0] c1 [3];
  logic signed [CW-1:0] c0 [3];
  logic signed [CW-1:0] c3_next [3];
  logic signed [CW-1:0] c3x3_next [3];
  logic signed [CW-1:0] c2_next [3];
  logic signed [CW-1:0] c1_next [3];
  logic signed [CW-1:0] c0_next [3];

  logic signed [MW-1:0] mh1 [3];
  logic signed [MW-1:0] mg1 [3];
  logic signed [CW-1:0] c2b [3];
  logic signed [CW-1:0] c1b [3];
  logic signed [CW-1:0] c0b [3];
  logic signed [CW-1:0] h1 [3];
  logic signed [CW-1:0] g1 [3];
  logic signed [CW-1:0] c1c [3];
  logic signed [CW-1:0] c0c [3];
  logic signed [MW-1:0] mh2 [3];
  logic signed [MW-1:0] mg2 [3];
  logic signed [CW-1:0] c1d [3];
  logic signed [CW-1:0] c0d [3];
  logic signed [CW-1:0] h2 [3];
  logic signed [CW-1:0] tan5 [3];
  logic signed [CW-1:0] c0e [3];
  logic signed [MW-1:0] mh3 [3];
  logic signed [CW-1:0] tan6 [3];
  logic signed [CW-1:0] c0f [3];
  logic signed [OW-1:0] pos7 [3];
  logic signed [OW-1:0] tan7 [3];

  logic signed [CW-1:0] h1_next [3];
  logic signed [CW-1:0] g1_next [3];
  logic signed [CW-1:0] h2_next [3];
  logic signed [CW-1:0] tan5_next [3];
  logic signed [OW-1:0] pos7_next [3];
  logic signed [OW-1:0] tan7_next [3];

  assign credit_ok = (LW + 1)'(inflight) + (LW + 1)'(res_level)
                     < (LW + 1)'(crcurve_pkg::RES_DEPTH);
  assign cmd_pop = !cmd_empty && (cmd.is_load || credit_ok);
  assign issue = cmd_pop && !cmd.is_load;
  assign res_push = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (issue && !v7) begin
      inflight <= inflight + 1'b1;
    end else if (v7 && !issue) begin
      inflight <= inflight - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_load && !cmd.err) begin
      mem0[cmd.waddr[AW-1:0]] <= {cmd.z, cmd.y, cmd.x};
      mem1[cmd.waddr[AW-1:0]] <= {cmd.z, cmd.y, cmd.x};
      mem2[cmd.waddr[AW-1:0]] <= {cmd.z, cmd.y, cmd.x};
      mem3[cmd.waddr[AW-1:0]] <= {cmd.z, cmd.y, cmd.x};
    end
    rd0 <= mem0[cmd.ra0[AW-1:0]];
    rd1 <= mem1[cmd.ra1[AW-1:0]];
    rd2 <= mem2[cmd.ra2[AW-1:0]];
    rd3 <= mem3[cmd.ra3[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v0, v1, v2, v3, v4, v5, v6, v7} <= '0;
    end else begin
      {v0, v1, v2, v3, v4, v5, v6, v7} <= {issue, v0, v1, v2, v3, v4, v5, v6};
    end
  end

  always_ff @(posedge clk) begin
    {e0, e1, e2, e3, e4, e5, e6, e7} <= {cmd.err, e0, e1, e2, e3, e4, e5, e6};
    t0 <= cmd.tt[FRAC_BITS-1:0];
    t1 <= t0;
    t2 <= t1;
    t3 <= t2;
    t4 <= t3;
    t5 <= t4;
  end

  always_comb begin
    logic signed [CW-1:0] p0, p1, p2, p3;
    for (int c = 0; c < 3; c++) begin
      p0 = CW'($signed(rd0[32*c +: 32]));
      p1 = CW'($signed(rd1[32*c +: 32]));
      p2 = CW'($signed(rd2[32*c +: 32]));
      p3 = CW'($signed(rd3[32*c +: 32]));
      c3_next[c] = -p0 + (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3;
      c3x3_next[c] = (c3_next[c] <<< 1) + c3_next[c];
      c2_next[c] = (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
      c1_next[c] = p2 - p0;
      c0_next[c] = p1 <<< 1;
    end
  end

  always_comb begin
    logic signed [MW-1:0] sa, sb;
    for (int c = 0; c < 3; c++) begin
      sa = mh1[c] + HALF;
      sb = mg1[c] + HALF;
      h1_next[c] = CW'(sa >>> FRAC_BITS) + c2b[c];
      g1_next[c] = CW'(sb >>> FRAC_BITS) + (c2b[c] <<< 1);
    end
  end

  always_comb begin
    logic signed [MW-1:0] sa, sb;
    logic signed [CW-1:0] g2;
    for (int c = 0; c < 3; c++) begin
      sa = mh2[c] + HALF;
      sb = mg2[c] + HALF;
      h2_next[c] = CW'(sa >>> FRAC_BITS) + c1d[c];
      g2 = CW'(sb >>> FRAC_BITS) + c1d[c];
      tan5_next[c] = (g2 + ONE) >>> 1;
    end
  end

  always_comb begin
    logic signed [MW-1:0] sa;
    logic signed [CW-1:0] h3, hr;
    for (int c = 0; c < 3; c++) begin
      sa = mh3[c] + HALF;
      h3 = CW'(sa >>> FRAC_BITS) + c0f[c];
      hr = (h3 + ONE) >>> 1;
      pos7_next[c] = e6 ? '0 : OW'(hr);
      tan7_next[c] = e6 ? '0 : OW'(tan6[c]);
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      c3[c] <= c3_next[c];
      c3x3[c] <= c3x3_next[c];
      c2[c] <= c2_next[c];
      c1[c] <= c1_next[c];
      c0[c] <= c0_next[c];

      mh1[c] <= MW'(c3[c]) * MW'($signed({1'b0, t1}));
      mg1[c] <= MW'(c3x3[c]) * MW'($signed({1'b0, t1}));
      c2b[c] <= c2[c];
      c1b[c] <= c1[c];
      c0b[c] <= c0[c];

      h1[c] <= h1_next[c];
      g1[c] <= g1_next[c];
      c1c[c] <= c1b[c];
      c0c[c] <= c0b[c];

      mh2[c] <= MW'(h1[c]) * MW'($signed({1'b0, t3}));
      mg2[c] <= MW'(g1[c]) * MW'($signed({1'b0, t3}));
      c1d[c] <= c1c[c];
      c0d[c] <= c0c[c];

      h2[c] <= h2_next[c];
      tan5[c] <= tan5_next[c];
      c0e[c] <= c0d[c];

      mh3[c] <= MW'(h2[c]) * MW'($signed({1'b0, t5}));
      tan6[c] <= tan5[c];
      c0f[c] <= c0e[c];

      pos7[c] <= pos7_next[c];
      tan7[c] <= tan7_next[c];
    end
  end

  always_comb begin
    res.pos_x = pos7[0];
    res.pos_y = pos7[1];
    res.pos_z = pos7[2];
    res.tangent_x = tan7[0];
    res.tangent_y = tan7[1];
    res.tangent_z = tan7[2];
    res.range_error = e7;
  end

endmodule

// File: design/catmull_rom_closed_curve_eval.sv
// Closed Catmull-Rom curve evaluator over a store of 3-D control points.
// Input channel: push/full. A load item (op = 0) writes one point into the
// store; an evaluate item (op = 1) names a curve by base address and point
// count and gives a global parameter, and yields one result.
// Result channel: empty/pop. The oldest result sits on the result ports
// while empty is low and is taken by a transfer with pop high.
// Items enter a four-entry command queue; the back end drains it at one
// command per cycle, holding back evaluations when result space runs out,
// and runs them through an eight-stage pipeline (store read, coefficients,
// three multiply/round steps) into a sixteen-entry result queue.
// Throughput: one item per cycle while the result queue does not back up.
// The back end only issues an evaluation while the result queue plus the
// work in flight has room, so a stalled receiver fills the result queue,
// then the command queue, and full rises; nothing is dropped.
// Reset empties both queues and the pipeline; the point store is not
// cleared and an entry must be loaded before a curve reads it.
module catmull_rom_closed_curve_eval #(
  parameter int STORE_DEPTH = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                op,
  input  logic [7:0]          point_addr,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  input  logic [7:0]          curve_base,
  input  logic [8:0]          curve_points,
  input  logic [15:0]         global_param,
  output logic                empty,
  input  logic                pop,
  output logic signed [37:0]  pos_x,
  output logic signed [37:0]  pos_y,
  output logic signed [37:0]  pos_z,
  output logic signed [37:0]  tangent_x,
  output logic signed [37:0]  tangent_y,
  output logic signed [37:0]  tangent_z,
  output logic                range_error
);

  localparam int CMD_W = $bits(crcurve_pkg::cmd_t);
  localparam int RES_W = $bits(crcurve_pkg::result_t);

  crcurve_pkg::cmd_t in_cmd;
  crcurve_pkg::cmd_t q_cmd;
  crcurve_pkg::result_t res;
  crcurve_pkg::result_t out_res;
  logic cmd_empty;
  logic cmd_pop;
  logic res_push;
  logic res_full;
  logic [$clog2(crcurve_pkg::CMD_DEPTH):0] cmd_level;
  logic [$clog2(crcurve_pkg::RES_DEPTH):0] res_level;

  crcurve_front #(
    .STORE_DEPTH(STORE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .op(op),
    .point_addr(point_addr),
    .coord_x(coord_x),
    .coord_y(coord_y),
    .coord_z(coord_z),
    .curve_base(curve_base),
    .curve_points(curve_points),
    .global_param(global_param),
    .cmd(in_cmd)
  );

  crcurve_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(crcurve_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wdata(in_cmd),
    .full(full),
    .pop(cmd_pop),
    .rdata(q_cmd),
    .empty(cmd_empty),
    .level(cmd_level)
  );

  crcurve_back #(
    .STORE_DEPTH(STORE_DEPTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cmd(q_cmd),
    .cmd_empty(cmd_empty),
    .cmd_pop(cmd_pop),
    .res_level(res_level),
    .res_push(res_push),
    .res(res)
  );

  crcurve_fifo #(
    .WIDTH(RES_W),
    .DEPTH(crcurve_pkg::RES_DEPTH)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .wdata(res),
    .full(res_full),
    .pop(pop),
    .rdata(out_res),
    .empty(empty),
    .level(res_level)
  );

  logic unused_ok;
  assign unused_ok = res_full ^ (|cmd_level);

  assign pos_x = out_res.pos_x;
  assign pos_y = out_res.pos_y;
  assign pos_z = out_res.pos_z;
  assign tangent_x = out_res.tangent_x;
  assign tangent_y = out_res.tangent_y;
  assign tangent_z = out_res.tangent_z;
  assign range_error = out_res.range_error;

endmodule
